// File: rtl/core/gcb_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants for the great-circle bearing pipeline.
// -----------------------------------------------------------------------------
package gcb_pkg;

	localparam int ROT_W     = 34;
	localparam int VEC_W     = 36;
	localparam int BRG_MAX_W = 32;
	localparam int NLANES    = 3;
	localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam int SECTOR_SHIFT = 28;

	typedef struct packed {
		logic signed [31:0] start_lat;
		logic signed [31:0] start_lon;
		logic signed [31:0] end_lat;
		logic signed [31:0] end_lon;
	} gcb_in_t;

	typedef struct packed {
		logic [BRG_MAX_W-1:0] bearing;
		logic [3:0]           compass_sector;
	} gcb_out_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
		logic                    neg;
	} gcb_rot_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] u;
		logic signed [VEC_W-1:0] v;
		logic [31:0]             z;
		logic                    zero;
	} gcb_vec_t;

	function automatic logic [31:0] atan_bam(input int idx);
		logic [31:0] r;
		begin
			unique case (idx)
				0: r = 32'd536870912;
				1: r = 32'd316933406;
				2: r = 32'd167458907;
				3: r = 32'd85004756;
				4: r = 32'd42667331;
				5: r = 32'd21354465;
				6: r = 32'd10679838;
				7: r = 32'd5340245;
				8: r = 32'd2670163;
				9: r = 32'd1335087;
				10: r = 32'd667544;
				11: r = 32'd333772;
				12: r = 32'd166886;
				13: r = 32'd83443;
				14: r = 32'd41722;
				15: r = 32'd20861;
				16: r = 32'd10430;
				17: r = 32'd5215;
				18: r = 32'd2608;
				19: r = 32'd1304;
				20: r = 32'd652;
				21: r = 32'd326;
				22: r = 32'd163;
				23: r = 32'd81;
				24: r = 32'd41;
				25: r = 32'd20;
				26: r = 32'd10;
				27: r = 32'd5;
				28: r = 32'd3;
				29: r = 32'd1;
				30: r = 32'd1;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// File: rtl/core/gcb_rot_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gcb_rot_cell
// One rotation-mode CORDIC micro-rotation for three sin/cos lanes.
// -----------------------------------------------------------------------------
module gcb_rot_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld_i,
	input  gcb_pkg::gcb_rot_t [2:0]   d_i,
	output logic                      vld_o,
	output gcb_pkg::gcb_rot_t [2:0]   d_o
);
	import gcb_pkg::*;

	localparam logic signed [ROT_W-1:0] ATAN = $signed({2'b00, atan_bam(IDX)});

	gcb_rot_t [2:0] nxt;

	always_comb begin
		for (int l = 0; l < NLANES; l++) begin
			nxt[l].neg = d_i[l].neg;
			if (!d_i[l].z[ROT_W-1]) begin
				nxt[l].x = d_i[l].x - (d_i[l].y >>> IDX);
				nxt[l].y = d_i[l].y + (d_i[l].x >>> IDX);
				nxt[l].z = d_i[l].z - ATAN;
			end else begin
				nxt[l].x = d_i[l].x + (d_i[l].y >>> IDX);
				nxt[l].y = d_i[l].y - (d_i[l].x >>> IDX);
				nxt[l].z = d_i[l].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		d_o <= nxt;
	end

endmodule

// File: rtl/core/gcb_mix.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gcb_mix
// Two product stages forming the north and east components from sin/cos.
// -----------------------------------------------------------------------------
module gcb_mix (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld_i,
	input  gcb_pkg::gcb_rot_t [2:0]   d_i,
	output logic                      vld_o,
	output gcb_pkg::gcb_vec_t         d_o
);
	import gcb_pkg::*;

	logic signed [31:0] s1, c1, s2, c2, sd, cd;
	logic signed [63:0] p_a, p_t, p_e, p_n;
	logic signed [ROT_W-1:0] pa_s1, t_s1, east_s1;
	logic signed [31:0] cd_s1;
	logic vld_s1;
	logic signed [ROT_W:0] north;
	logic signed [VEC_W-1:0] nu, ev;

	always_comb begin
		s1 = d_i[0].neg ? -d_i[0].y[31:0] : d_i[0].y[31:0];
		c1 = d_i[0].neg ? -d_i[0].x[31:0] : d_i[0].x[31:0];
		s2 = d_i[1].neg ? -d_i[1].y[31:0] : d_i[1].y[31:0];
		c2 = d_i[1].neg ? -d_i[1].x[31:0] : d_i[1].x[31:0];
		sd = d_i[2].neg ? -d_i[2].y[31:0] : d_i[2].y[31:0];
		cd = d_i[2].neg ? -d_i[2].x[31:0] : d_i[2].x[31:0];
		p_a = c1 * s2;
		p_t = s1 * c2;
		p_e = sd * c2;
	end

	always_ff @(posedge clk) begin
		pa_s1   <= ROT_W'(p_a >>> 30);
		t_s1    <= ROT_W'(p_t >>> 30);
		east_s1 <= ROT_W'(p_e >>> 30);
		cd_s1   <= cd;
	end

	always_comb begin
		p_n   = $signed(t_s1[31:0]) * cd_s1;
		north = {pa_s1[ROT_W-1], pa_s1} - (ROT_W+1)'(p_n >>> 30);
		nu    = VEC_W'(north);
		ev    = VEC_W'(east_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		d_o.zero <= (north == '0) && (east_s1 == '0);
		if (north[ROT_W]) begin
			d_o.u <= -nu;
			d_o.v <= -ev;
			d_o.z <= HALF_TURN;
		end else begin
			d_o.u <= nu;
			d_o.v <= ev;
			d_o.z <= '0;
		end
	end

endmodule

// File: rtl/core/gcb_vec_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gcb_vec_cell
// One vectoring-mode CORDIC micro-rotation accumulating the bearing angle.
// -----------------------------------------------------------------------------
module gcb_vec_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_i,
	input  gcb_pkg::gcb_vec_t  d_i,
	output logic               vld_o,
	output gcb_pkg::gcb_vec_t  d_o
);
	import gcb_pkg::*;

	localparam logic [31:0] ATAN = atan_bam(IDX);

	gcb_vec_t nxt;

	always_comb begin
		nxt.zero = d_i.zero;
		if (d_i.v > 0) begin
			nxt.u = d_i.u + (d_i.v >>> IDX);
			nxt.v = d_i.v - (d_i.u >>> IDX);
			nxt.z = d_i.z + ATAN;
		end else begin
			nxt.u = d_i.u - (d_i.v >>> IDX);
			nxt.v = d_i.v + (d_i.u >>> IDX);
			nxt.z = d_i.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		d_o <= nxt;
	end

endmodule

// File: rtl/core/great_circle_bearing_compass.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// great_circle_bearing_compass
// Initial great-circle bearing and 16-point compass sector of a point pair.
// -----------------------------------------------------------------------------
// Fully pipelined: a new point pair is taken every cycle (busy is always low)
// and its result appears on the done strobe after passing through the rotation
// cell chain, two product stages, the vectoring cell chain and the output
// register. The receiver cannot stall; every result is valid for exactly one
// cycle. bearing uses the low BEARING_BITS bits of its field; the bits above
// read zero.
module great_circle_bearing_compass #(
	parameter int BEARING_BITS  = 16,
	parameter int CORDIC_STAGES = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gcb_pkg::gcb_in_t  operands,
	output logic              done,
	output gcb_pkg::gcb_out_t result
);
	import gcb_pkg::*;

	localparam int N     = CORDIC_STAGES;
	localparam int SHIFT = 32 - BEARING_BITS;
	localparam int LAT   = 2 * N + 3;
	localparam logic [32:0] HALF = (33'd1 << SHIFT) >> 1;

	logic [31:0] ang [3];
	gcb_rot_t [2:0] rot_d [N+1];
	logic rot_v [N+1];
	gcb_vec_t vec_d [N+1];
	logic vec_v [N+1];
	logic [31:0] z_fin;
	logic [32:0] z_rnd, z_sec;

	assign busy = 1'b0;

	assign ang[0] = operands.start_lat;
	assign ang[1] = operands.end_lat;
	assign ang[2] = operands.end_lon - operands.start_lon;

	always_comb begin
		logic [31:0] b;
		for (int l = 0; l < NLANES; l++) begin
			b = ang[l];
			rot_d[0][l].neg = 1'b0;
			if (ang[l][31:30] == 2'b01 || ang[l][31:30] == 2'b10) begin
				b = ang[l] + HALF_TURN;
				rot_d[0][l].neg = 1'b1;
			end
			rot_d[0][l].x = GAIN_Q30;
			rot_d[0][l].y = '0;
			rot_d[0][l].z = ROT_W'($signed(b));
		end
	end
	assign rot_v[0] = start;

	for (genvar g = 0; g < N; g++) begin : g_rot
		gcb_rot_cell #(.IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_i(rot_v[g]), .d_i(rot_d[g]),
			.vld_o(rot_v[g+1]), .d_o(rot_d[g+1])
		);
	end

	gcb_mix u_mix (
		.clk(clk), .arst_n(arst_n),
		.vld_i(rot_v[N]), .d_i(rot_d[N]),
		.vld_o(vec_v[0]), .d_o(vec_d[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_vec
		gcb_vec_cell #(.IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_i(vec_v[g]), .d_i(vec_d[g]),
			.vld_o(vec_v[g+1]), .d_o(vec_d[g+1])
		);
	end

	always_comb begin
		z_fin = vec_d[N].zero ? 32'd0 : vec_d[N].z;
		z_rnd = ({1'b0, z_fin} + HALF) >> SHIFT;
		z_sec = {1'b0, z_fin} + 33'((1 << SECTOR_SHIFT) - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vec_v[N];
		end
	end

	always_ff @(posedge clk) begin
		result.bearing        <= BRG_MAX_W'(z_rnd[BEARING_BITS-1:0]);
		result.compass_sector <= (z_fin == '0) ? 4'd0 : z_sec[31:28];
	end

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching transfer");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_v[N] && vec_d[N].zero) |=> (result.bearing == '0 && result.compass_sector == '0))
		else $error("zero vector gave nonzero bearing");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		rot_v[N] |-> ##(N+2) vec_v[N])
		else $error("item lost in pipeline");

endmodule

// File: dv/tb_great_circle_bearing_compass.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_great_circle_bearing_compass
// Self-checking bench for the great-circle bearing pipeline. A bit-exact
// CORDIC predictor computes bearing and compass sector for every point pair
// taken in. Each done strobe is checked against the oldest pending result.
// -----------------------------------------------------------------------------
module tb_great_circle_bearing_compass;
	import gcb_pkg::*;

	localparam int BBITS   = 16;
	localparam int NSTG    = 18;
	localparam int LATENCY = 2 * NSTG + 3;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	gcb_in_t  operands = '0;
	logic     done;
	gcb_out_t result;

	gcb_out_t bearing_q[$];
	int       n_err = 0;
	int       n_seen = 0;
	int       n_sent = 0;
	int       src_idle = 10;

	great_circle_bearing_compass #(.BEARING_BITS(BBITS), .CORDIC_STAGES(NSTG)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	always #4 clk = ~clk;

	function automatic longint atan_step(int i);
		longint tab[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
			20, 10, 5, 3, 1, 1, 0};
		return tab[i];
	endfunction

	function automatic void sin_cos(input logic [31:0] a, output longint s,
		output longint c);
		logic        flip;
		logic [31:0] b;
		longint      x, y, z, t;
		flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		b = flip ? a + 32'h8000_0000 : a;
		x = 652032874;
		y = 0;
		z = longint'($signed(b));
		for (int i = 0; i < NSTG; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
			end else begin
				t = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic gcb_out_t predict_bearing(gcb_in_t p);
		longint      s1, c1, s2, c2, sd, cd, nrt, est, t, u, v;
		logic [31:0] z;
		logic [32:0] r;
		gcb_out_t    o;
		sin_cos(p.start_lat, s1, c1);
		sin_cos(p.end_lat, s2, c2);
		sin_cos(p.end_lon - p.start_lon, sd, cd);
		t = (s1 * c2) >>> 30;
		nrt = ((c1 * s2) >>> 30) - ((t * cd) >>> 30);
		est = (sd * c2) >>> 30;
		z = '0;
		if (nrt != 0 || est != 0) begin
			u = nrt; v = est;
			if (u < 0) begin
				u = -u; v = -v; z = 32'h8000_0000;
			end
			for (int i = 0; i < NSTG; i++) begin
				if (v > 0) begin
					t = u + (v >>> i); v = v - (u >>> i); z += 32'(atan_step(i));
				end else begin
					t = u - (v >>> i); v = v + (u >>> i); z -= 32'(atan_step(i));
				end
				u = t;
			end
		end
		r = ({1'b0, z} + (33'd1 << (31 - BBITS))) >> (32 - BBITS);
		o = '0;
		o.bearing = 32'(r[BBITS-1:0]);
		o.compass_sector = (z == 0) ? 4'd0 : 4'((({4'd0, z} + 36'hFFF_FFFF) >> 28) & 15);
		return o;
	endfunction

	task automatic send_pair(input gcb_in_t p);
		while ($urandom_range(99) < src_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operands <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		bearing_q.push_back(predict_bearing(p));
		n_sent++;
	endtask

	always @(posedge clk) begin
		if (done) begin
			n_seen++;
			if (bearing_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result %h", result);
			end else begin
				gcb_out_t e;
				e = bearing_q.pop_front();
				if (result.bearing !== e.bearing ||
					result.compass_sector !== e.compass_sector) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp brg %h sec %0d, got brg %h sec %0d",
							e.bearing, e.compass_sector, result.bearing,
							result.compass_sector);
				end
			end
		end
	end

	function automatic gcb_in_t mk(int a, int b, int c, int d);
		gcb_in_t p;
		p.start_lat = a; p.start_lon = b; p.end_lat = c; p.end_lon = d;
		return p;
	endfunction

	function automatic logic [31:0] rnd_lat();
		return $urandom_range(32'h8000_0000) - 32'h4000_0000;
	endfunction

	task automatic test_directed();
		int q = 32'h4000_0000;
		send_pair(mk(0, 0, 0, 0));
		send_pair(mk(q, 5, q, 5));
		send_pair(mk(-q, 0, -q, 0));
		send_pair(mk(q, 0, -q, 100));
		send_pair(mk(0, 0, 0, 32'h8000_0000));
		send_pair(mk(0, 32'h7FFF_FFFF, 0, 32'h8000_0000));
		send_pair(mk(0, 32'h8000_0000, 0, 32'h7FFF_FFFF));
		send_pair(mk(0, 0, 1000, 0));
		send_pair(mk(1000, 0, 0, 0));
		send_pair(mk(0, 0, 0, 1000));
		send_pair(mk(0, 1000, 0, 0));
		send_pair(mk(12345, 0, -54321, -777));
		send_pair(mk(q, 123, 0, 0));
		send_pair(mk(-q, 0, q, 32'h7FFF_FFFF));
		send_pair(mk(32'h3000_0000, 32'h1000_0000, 32'hD000_0000, 32'hF000_0000));
		send_pair(mk(-1, -1, -1, -1));
		for (int k = 0; k < 8; k++)
			send_pair(mk(0, 0, $urandom_range(1 << 24), $urandom_range(1 << 28) << k));
	endtask

	task automatic test_random(input int n);
		gcb_in_t p;
		for (int k = 0; k < n; k++) begin
			p = mk(rnd_lat(), $urandom(), rnd_lat(), $urandom());
			case ($urandom_range(4))
				0: p.end_lat = p.start_lat;
				1: p.end_lon = p.start_lon + $urandom_range(255) - 128;
				2: p = mk($urandom(), $urandom(), $urandom(), $urandom());
				default: ;
			endcase
			send_pair(p);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (bearing_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		src_idle = 10;
		test_random(160);
		drain_results();
		src_idle = 85;
		test_random(160);
		src_idle = 0;
		test_random(160);
		drain_results();
		$display("sent %0d point pairs, checked %0d results over three idle mixes",
			n_sent, n_seen);
		if (n_err == 0 && bearing_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
